// ===== sv/in_order_result_reorder_core_assert.svh =====
// ----------------------------------------------------------------------------
// Reorder core assertion macros
// Shared property forms for the checkers of the in-order result reorder core.
// ----------------------------------------------------------------------------
`ifndef IN_ORDER_RESULT_REORDER_CORE_ASSERT_SVH
`define IN_ORDER_RESULT_REORDER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RORB_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("reorder core check failed");

// The consequent must hold in the cycle after the antecedent.
`define RORB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("reorder core check failed");

`endif

// ===== sv/rorb_pkg.sv =====
// ----------------------------------------------------------------------------
// Reorder core package
// Item types and fixed constants of the in-order result reorder core.
// ----------------------------------------------------------------------------
`default_nettype none

package rorb_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   localparam logic STATUS_EMITTED = 1'b0;
   localparam logic STATUS_DROPPED = 1'b1;

   typedef struct packed {
      logic [15:0] sequence_number;
      logic [7:0]  move_count;
      logic [47:0] probe_count;
      logic [31:0] payload_handle;
   } req_type;

   typedef struct packed {
      logic [15:0] out_sequence;
      logic [31:0] out_payload;
      logic [47:0] out_probes;
      logic        last_of_run;
      logic        status;
      logic [31:0] solved_total;
      logic [31:0] missed_total;
      logic [63:0] probe_total;
   } rsp_type;

   typedef struct packed {
      logic [15:0] sequence_number;
      logic [31:0] payload_handle;
      logic [47:0] probe_count;
   } slot_type;

endpackage

`default_nettype wire

// ===== sv/rorb_slot_mem.sv =====
// ----------------------------------------------------------------------------
// Reorder slot memory
// Window slot storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rorb_slot_mem #(
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire rorb_pkg::slot_type wr_data,
   input  wire logic               rd_en,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output rorb_pkg::slot_type      rd_data
);

   rorb_pkg::slot_type mem_ff [DEPTH];
   rorb_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/in_order_result_reorder_core.sv =====
// ----------------------------------------------------------------------------
// In-order result reorder core
// Releases sequence-tagged results in order, parking early ones in a window.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. Results
// appear on rsp_data for one cycle each, marked by rsp_strobe; the receiver
// cannot stall them. csr_wr_en writes the target move limit at once.
// An item ahead of the expected sequence, inside the window, is parked and
// keeps busy high only in the classify state. An item outside the window is
// dropped there; its single dropped result shows in the first idle cycle.
// An item that matches the expected sequence releases a run of n results
// (itself plus up to n-1 parked successors, n at most 16). A scan over the
// window slots, one slot a cycle through the single read port of the slot
// memory and one shared 64-bit adder, comes before the run is emitted.
// Busy stays high through the classify, scan and emit states; the n results
// follow in consecutive cycles, the last one in the first idle cycle.
// Reset clears all control state and counters and sets the expected sequence
// to 1; the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module in_order_result_reorder_core #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rorb_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output rorb_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wr_en,
   input  wire logic [7:0]        csr_wr_data
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = rorb_pkg::CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   rorb_pkg::req_type      item_ff, item_in;
   logic [15:0]            dist_ff, dist_in;
   logic [15:0]            expected_ff, expected_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [IDX_W-1:0]       emit_ptr_ff, emit_ptr_in;
   logic [WINDOW_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       emit_idx_ff, emit_idx_in;
   logic                   pend_ff, pend_in;
   logic [31:0]            solved_ff, solved_in;
   logic [31:0]            missed_ff, missed_in;
   logic [63:0]            sum_ff, sum_in;
   logic [7:0]             target_ff, target_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rorb_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   rorb_pkg::slot_type     wr_data;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   rorb_pkg::slot_type     rd_data;

   logic [IDX_W-1:0]       head_next;
   logic [IDX_W-1:0]       emit_ptr_next;
   logic [IDX_W:0]         slot_sum;
   logic [IDX_W-1:0]       slot_addr;
   logic [47:0]            add_operand;
   logic [63:0]            add_result;
   logic                   scan_issue;
   logic                   emit_last;

   always_comb begin
      head_next     = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      emit_ptr_next = (emit_ptr_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : emit_ptr_ff + 1'b1;
      slot_sum      = {1'b0, head_ff} + {1'b0, dist_ff[IDX_W-1:0]};
      if (slot_sum >= (IDX_W + 1)'(WINDOW_DEPTH)) begin
         slot_addr = IDX_W'(slot_sum - (IDX_W + 1)'(WINDOW_DEPTH));
      end else begin
         slot_addr = slot_sum[IDX_W-1:0];
      end
      add_operand = (state_ff == ST_CLASSIFY) ? item_ff.probe_count : rd_data.probe_count;
      add_result  = sum_ff + {16'b0, add_operand};
      scan_issue  = valid_ff[head_ff] && (cnt_ff < CNT_W'(rorb_pkg::MAX_RESULTS));
      emit_last   = (emit_idx_ff + CNT_W'(1)) == cnt_ff;
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      dist_in       = dist_ff;
      expected_in   = expected_ff;
      head_in       = head_ff;
      emit_ptr_in   = emit_ptr_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      emit_idx_in   = emit_idx_ff;
      pend_in       = 1'b0;
      solved_in     = solved_ff;
      missed_in     = missed_ff;
      sum_in        = sum_ff;
      target_in     = csr_wr_en ? csr_wr_data : target_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_addr;
      wr_data       = '{sequence_number: item_ff.sequence_number,
                        payload_handle:  item_ff.payload_handle,
                        probe_count:     item_ff.probe_count};
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in   = req_data;
               dist_in   = req_data.sequence_number - expected_ff;
               solved_in = solved_ff + 32'd1;
               if ((target_ff != 8'd0) && (req_data.move_count > target_ff)) begin
                  missed_in = missed_ff + 32'd1;
               end
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (dist_ff == 16'd0) begin
               valid_in[head_ff] = 1'b0;
               sum_in            = add_result;
               expected_in       = expected_ff + 16'd1;
               head_in           = head_next;
               emit_ptr_in       = head_next;
               cnt_in            = CNT_W'(1);
               state_in          = ST_SCAN;
            end else if (dist_ff < 16'(WINDOW_DEPTH)) begin
               wr_en              = 1'b1;
               valid_in[slot_addr] = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in = '{out_sequence: item_ff.sequence_number,
                          out_payload:  item_ff.payload_handle,
                          out_probes:   item_ff.probe_count,
                          last_of_run:  1'b1,
                          status:       rorb_pkg::STATUS_DROPPED,
                          solved_total: solved_ff,
                          missed_total: missed_ff,
                          probe_total:  sum_ff};
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (pend_ff) begin
               sum_in = add_result;
            end
            if (scan_issue) begin
               rd_en             = 1'b1;
               rd_addr           = head_ff;
               pend_in           = 1'b1;
               valid_in[head_ff] = 1'b0;
               head_in           = head_next;
               expected_in       = expected_ff + 16'd1;
               cnt_in            = cnt_ff + CNT_W'(1);
            end else begin
               emit_idx_in = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rd_addr = emit_ptr_ff;
            if (!emit_last) begin
               rd_en       = 1'b1;
               emit_ptr_in = emit_ptr_next;
            end
            rsp_strobe_in = 1'b1;
            if (emit_idx_ff == '0) begin
               rsp_in.out_sequence = item_ff.sequence_number;
               rsp_in.out_payload  = item_ff.payload_handle;
               rsp_in.out_probes   = item_ff.probe_count;
            end else begin
               rsp_in.out_sequence = rd_data.sequence_number;
               rsp_in.out_payload  = rd_data.payload_handle;
               rsp_in.out_probes   = rd_data.probe_count;
            end
            rsp_in.last_of_run  = emit_last;
            rsp_in.status       = rorb_pkg::STATUS_EMITTED;
            rsp_in.solved_total = solved_ff;
            rsp_in.missed_total = missed_ff;
            rsp_in.probe_total  = sum_ff;
            emit_idx_in = emit_idx_ff + CNT_W'(1);
            if (emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         expected_ff   <= 16'd1;
         head_ff       <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         solved_ff     <= '0;
         missed_ff     <= '0;
         sum_ff        <= '0;
         target_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         expected_ff   <= expected_in;
         head_ff       <= head_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         solved_ff     <= solved_in;
         missed_ff     <= missed_in;
         sum_ff        <= sum_in;
         target_ff     <= target_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      item_ff     <= item_in;
      dist_ff     <= dist_in;
      emit_ptr_ff <= emit_ptr_in;
      emit_idx_ff <= emit_idx_in;
      rsp_ff      <= rsp_in;
   end

   rorb_slot_mem #(
      .DEPTH(WINDOW_DEPTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/rorb_checker.sv =====
// ----------------------------------------------------------------------------
// Reorder core port checker
// Port-level properties of the in-order result reorder core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "in_order_result_reorder_core_assert.svh"

module rorb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire rorb_pkg::rsp_type rsp_data
);

   // Taking an item always makes the block busy.
   `RORB_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // A dropped item is always a run of its own.
   `RORB_ASSERT_SAME(a_drop_single, clock, reset,
      rsp_strobe && (rsp_data.status == rorb_pkg::STATUS_DROPPED), rsp_data.last_of_run)

   // A run is delivered in consecutive cycles.
   `RORB_ASSERT_NEXT(a_run_contiguous, clock, reset,
      rsp_strobe && !rsp_data.last_of_run, rsp_strobe)

   // All items of one run report the same totals.
   `RORB_ASSERT_NEXT(a_run_totals, clock, reset, rsp_strobe && !rsp_data.last_of_run,
      $stable(rsp_data.probe_total) && $stable(rsp_data.solved_total)
      && $stable(rsp_data.missed_total))

endmodule

bind in_order_result_reorder_core rorb_checker u_rorb_checker (.*);

`default_nettype wire

// ===== tb/tb_in_order_result_reorder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-order result reorder core testbench
// Sends sequence-tagged result items in order, out of order, duplicated, old
// and far ahead of the window, under several target move limits. A local model
// of the reorder window and its counters predicts every released or dropped
// item, and each result the core emits is checked field by field.
// ----------------------------------------------------------------------------
module tb_in_order_result_reorder_core;

   localparam int DEPTH         = 16;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 1000;

   logic              clock;
   logic              reset       = 1'b1;
   logic              start       = 1'b0;
   logic              busy;
   rorb_pkg::req_type req_data    = '0;
   logic              rsp_strobe;
   rorb_pkg::rsp_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [7:0]        csr_wr_data = '0;

   logic [7:0]         model_target    = '0;
   logic [15:0]        model_next_seq  = 16'd1;
   int                 model_head      = 0;
   bit                 model_parked [DEPTH];
   rorb_pkg::slot_type model_slots [DEPTH];
   logic [31:0]        model_solved    = '0;
   logic [31:0]        model_missed    = '0;
   logic [63:0]        model_probe_sum = '0;
   rorb_pkg::rsp_type  release_queue [$];

   bit gaps_on      = 1'b1;
   int items_sent   = 0;
   int results_seen = 0;
   int drops_seen   = 0;
   int csr_writes   = 0;
   int error_count  = 0;
   int stall_cycles = 0;

   in_order_result_reorder_core #(.WINDOW_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic advance_reorder_model(input rorb_pkg::req_type item);
      rorb_pkg::rsp_type run [$];
      rorb_pkg::rsp_type entry;
      logic [15:0]       seq_gap;
      int                slot;
      model_solved = model_solved + 1;
      if (item.move_count != 0 && model_target != 0 && item.move_count > model_target) begin
         model_missed = model_missed + 1;
      end
      seq_gap = item.sequence_number - model_next_seq;
      entry   = '0;
      if (seq_gap == 0) begin
         model_parked[model_head] = 1'b0;
         entry.out_sequence = item.sequence_number;
         entry.out_payload  = item.payload_handle;
         entry.out_probes   = item.probe_count;
         entry.status       = rorb_pkg::STATUS_EMITTED;
         run.push_back(entry);
         model_probe_sum = model_probe_sum + item.probe_count;
         model_next_seq  = model_next_seq + 16'd1;
         model_head      = (model_head + 1) % DEPTH;
         while (run.size() < rorb_pkg::MAX_RESULTS && model_parked[model_head]) begin
            model_parked[model_head] = 1'b0;
            entry.out_sequence = model_slots[model_head].sequence_number;
            entry.out_payload  = model_slots[model_head].payload_handle;
            entry.out_probes   = model_slots[model_head].probe_count;
            run.push_back(entry);
            model_probe_sum = model_probe_sum + model_slots[model_head].probe_count;
            model_next_seq  = model_next_seq + 16'd1;
            model_head      = (model_head + 1) % DEPTH;
         end
      end else if (seq_gap < DEPTH) begin
         slot = (model_head + seq_gap) % DEPTH;
         model_parked[slot] = 1'b1;
         model_slots[slot].sequence_number = item.sequence_number;
         model_slots[slot].payload_handle  = item.payload_handle;
         model_slots[slot].probe_count     = item.probe_count;
         return;
      end else begin
         entry.out_sequence = item.sequence_number;
         entry.out_payload  = item.payload_handle;
         entry.out_probes   = item.probe_count;
         entry.status       = rorb_pkg::STATUS_DROPPED;
         run.push_back(entry);
      end
      foreach (run[k]) begin
         run[k].last_of_run  = (k == run.size() - 1);
         run[k].solved_total = model_solved;
         run[k].missed_total = model_missed;
         run[k].probe_total  = model_probe_sum;
         release_queue.push_back(run[k]);
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rorb_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rsp_data.status === rorb_pkg::STATUS_DROPPED) begin
            drops_seen++;
         end
         if (release_queue.size() == 0) begin
            $error("unexpected result with sequence 0x%0h", rsp_data.out_sequence);
            error_count++;
         end else begin
            want = release_queue.pop_front();
            compare_field("out_sequence", 64'(want.out_sequence), 64'(rsp_data.out_sequence));
            compare_field("out_payload", 64'(want.out_payload), 64'(rsp_data.out_payload));
            compare_field("out_probes", 64'(want.out_probes), 64'(rsp_data.out_probes));
            compare_field("last_of_run", 64'(want.last_of_run), 64'(rsp_data.last_of_run));
            compare_field("status", 64'(want.status), 64'(rsp_data.status));
            compare_field("solved_total", 64'(want.solved_total), 64'(rsp_data.solved_total));
            compare_field("missed_total", 64'(want.missed_total), 64'(rsp_data.missed_total));
            compare_field("probe_total", want.probe_total, rsp_data.probe_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic rorb_pkg::req_type build_item(input logic [15:0] seq,
                                                    input logic [7:0] moves,
                                                    input logic [47:0] probes,
                                                    input logic [31:0] handle);
      rorb_pkg::req_type item;
      item.sequence_number = seq;
      item.move_count      = moves;
      item.probe_count     = probes;
      item.payload_handle  = handle;
      return item;
   endfunction

   function automatic rorb_pkg::req_type make_item(input logic [15:0] seq);
      logic [7:0]  moves;
      logic [47:0] probes;
      logic [31:0] handle;
      case ($urandom_range(0, 7))
         0: moves = 8'h00;
         1: moves = 8'hFF;
         default: moves = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: probes = '0;
         1: probes = '1;
         default: probes = {16'($urandom), $urandom};
      endcase
      case ($urandom_range(0, 7))
         0: handle = '0;
         1: handle = '1;
         default: handle = $urandom;
      endcase
      return build_item(seq, moves, probes, handle);
   endfunction

   task automatic send_item(input rorb_pkg::req_type item);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      advance_reorder_model(item);
      items_sent++;
   endtask

   task automatic settle_core();
      start <= 1'b0;
      while (release_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_target(input logic [7:0] value);
      settle_core();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      model_target  = value;
      csr_writes++;
   endtask

   task automatic test_boundary_values();
      send_item(build_item(16'd1, 8'hFF, '1, '1));
      send_item(build_item(16'd2, 8'h00, '0, '0));
   endtask

   task automatic test_parking_and_duplicates();
      logic [15:0] base;
      base = model_next_seq;
      send_item(make_item(base + 16'd1));
      send_item(make_item(base + 16'd2));
      send_item(make_item(base + 16'd1));
      send_item(make_item(base));
   endtask

   task automatic test_drops_and_window_edge();
      send_item(make_item(model_next_seq - 16'd1));
      send_item(make_item(model_next_seq + 16'(DEPTH)));
      send_item(make_item(16'h0000));
      send_item(make_item(16'hFFFF));
      send_item(make_item(model_next_seq + 16'(DEPTH - 1)));
      send_item(make_item(model_next_seq));
   endtask

   task automatic test_miss_threshold();
      write_target(8'hFF);
      send_item(build_item(model_next_seq, 8'hFF, 48'd5, 32'h1));
      send_item(build_item(model_next_seq, 8'hFE, 48'd6, 32'h2));
      write_target(8'h01);
      send_item(build_item(model_next_seq, 8'h00, 48'd7, 32'h3));
      send_item(build_item(model_next_seq, 8'h01, 48'd8, 32'h4));
      send_item(build_item(model_next_seq, 8'h02, 48'd9, 32'h5));
   endtask

   task automatic test_full_window();
      logic [15:0] base;
      write_target(8'($urandom_range(2, 254)));
      base = model_next_seq;
      for (int d = DEPTH - 1; d > 0; d--) begin
         send_item(make_item(base + 16'(d)));
      end
      send_item(make_item(base));
   endtask

   task automatic test_random_traffic(input int count, input logic [7:0] target,
                                      input bit allow_gaps);
      int          order [DEPTH];
      int          span;
      int          sent;
      int          j;
      int          tmp;
      logic [15:0] base;
      write_target(target);
      sent = 0;
      while (sent < count) begin
         gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            8: begin
               send_item(make_item(16'($urandom)));
               sent++;
            end
            9: begin
               send_item(make_item(model_next_seq - 16'($urandom_range(1, 40))));
               sent++;
            end
            default: begin
               span = $urandom_range(1, DEPTH);
               base = model_next_seq;
               for (int i = 0; i < span; i++) begin
                  order[i] = i;
               end
               for (int i = span - 1; i > 0; i--) begin
                  j        = $urandom_range(0, i);
                  tmp      = order[i];
                  order[i] = order[j];
                  order[j] = tmp;
               end
               for (int i = 0; i < span && sent < count; i++) begin
                  send_item(make_item(base + 16'(order[i])));
                  sent++;
                  if ($urandom_range(0, 5) == 0) begin
                     send_item(make_item(base + 16'(order[$urandom_range(0, i)])));
                     sent++;
                  end
               end
            end
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_boundary_values();
      test_parking_and_duplicates();
      test_drops_and_window_edge();
      test_miss_threshold();
      test_full_window();
      test_random_traffic(35, 8'($urandom_range(1, 254)), 1'b1);
      test_random_traffic(35, 8'h00, 1'b0);
      settle_core();
      $display("Sent %0d items under %0d target limit writes.", items_sent, csr_writes);
      $display("Checked %0d released or dropped results, %0d of them drops.",
               results_seen, drops_seen);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
